FILE: sv/vpyd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpyd_pkg
// Shared widths, pipeline item types and the sin^2 degree table.
// ----------------------------------------------------------------------------
package vpyd_pkg;

    localparam int CW        = 24;
    localparam int SQ_W      = 2 * CW;
    localparam int D_W       = 2 * CW + 2;
    localparam int HALF_W    = (D_W + 1) / 2;
    localparam int TAB_W     = 64;
    localparam int K_W       = 7;
    localparam int TAB_DEPTH = 1 << K_W;
    localparam int DEG_COUNT = 90;
    localparam int SEARCH_STEPS = K_W;
    localparam int DEG_W     = 9;

    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

    localparam logic [159:0] PI_Q126 = 160'h0_C90FDAA2_2168C234_C4C6628B_80DC1CD1;

    typedef logic [TAB_W-1:0] sin2_tab_t [TAB_DEPTH];

    typedef struct packed {
        logic [D_W-1:0] n;
        logic [D_W-1:0] d;
        logic [K_W-1:0] k;
        logic           whole;
        logic           full;
    } angle_t;

    typedef struct packed {
        angle_t yaw;
        angle_t pitch;
        logic   nx;
        logic   ny;
        logic   nz;
        logic   hzero;
    } item_t;

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[125:62];
    endfunction

    // shift and subtract quotient, only used while building the table
    function automatic logic [159:0] long_div(logic [159:0] num, logic [159:0] den);
        logic [160:0] rem;
        logic [159:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 159; b >= 0; b--)
        begin
            rem = {rem[159:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] deg_to_rad(logic [7:0] k);
        logic [159:0] p;
        logic [159:0] q;
        p = PI_Q126 * {152'd0, k};
        q = long_div(p, 160'd180);
        return q[127:64] + {63'd0, q[63]};
    endfunction

    function automatic sin2_tab_t build_sin2_tab();
        sin2_tab_t    t;
        logic [63:0]  th;
        logic [63:0]  th2;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  div;
        logic [127:0] sq;
        logic         done;
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            t[k] = '0;
        end
        for (int k = 0; k < DEG_COUNT; k++)
        begin
            th   = deg_to_rad(8'(k));
            th2  = mul_q62(th, th);
            sum  = th;
            term = th;
            done = 1'b0;
            for (int i = 1; i < 40; i++)
            begin
                if (!done)
                begin
                    div  = 64'((2 * i) * (2 * i + 1));
                    term = 64'(long_div({96'd0, mul_q62(term, th2)}, {96'd0, div}));
                    if (term == 64'd0)
                    begin
                        done = 1'b1;
                    end
                    else if ((i % 2) == 1)
                    begin
                        sum = sum - term;
                    end
                    else
                    begin
                        sum = sum + term;
                    end
                end
            end
            sq   = {64'd0, sum} * {64'd0, sum};
            t[k] = sq[123:60] + {63'd0, sq[59]};
        end
        t[0]  = 64'd0;
        t[30] = 64'h4000_0000_0000_0000;
        t[45] = 64'h8000_0000_0000_0000;
        t[60] = 64'hC000_0000_0000_0000;
        return t;
    endfunction

    localparam sin2_tab_t SIN2_TAB = build_sin2_tab();

endpackage

FILE: sv/vpyd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpyd_in_if
// Request channel carrying one direction vector.
// ----------------------------------------------------------------------------
interface vpyd_in_if
    import vpyd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

FILE: sv/vpyd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpyd_out_if
// Result channel carrying pitch and yaw in whole degrees.
// ----------------------------------------------------------------------------
interface vpyd_out_if
    import vpyd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] pitch_deg;
    logic [DEG_W-1:0] yaw_deg;

    modport source (output valid, output pitch_deg, output yaw_deg, input ready);
    modport sink   (input valid, input pitch_deg, input yaw_deg, output ready);
endinterface

FILE: sv/vector_to_pitch_yaw_degrees_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw_degrees_core
// Direction vector to pitch and yaw in whole degrees, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one vector per cycle while the result side is not stalled: three
// stages form magnitudes and sums of squares, then seven binary search steps
// of two stages each (table multiply, then exact compare against sin^2 of
// whole degrees) pick the floor angle, and one stage folds quadrant and sign.
// Results are exact truncations; stalls on the result side back up stage by
// stage, so empty stages still take requests.
module vector_to_pitch_yaw_degrees_core
    import vpyd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    vpyd_in_if.sink      vec,
    vpyd_out_if.source   angles
);

    logic  v   [SEARCH_STEPS+1];
    logic  r   [SEARCH_STEPS+1];
    item_t itm [SEARCH_STEPS+1];

    vpyd_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec.valid),
        .in_ready  (vec.ready),
        .vec_x     (vec.vec_x),
        .vec_y     (vec.vec_y),
        .vec_z     (vec.vec_z),
        .out_valid (v[0]),
        .out_ready (r[0]),
        .out_item  (itm[0])
    );

    for (genvar s = 0; s < SEARCH_STEPS; s++)
    begin : g_step
        vpyd_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_bit  (K_W'(1) << (SEARCH_STEPS - 1 - s)),
            .in_valid  (v[s]),
            .in_ready  (r[s]),
            .in_item   (itm[s]),
            .out_valid (v[s+1]),
            .out_ready (r[s+1]),
            .out_item  (itm[s+1])
        );
    end

    vpyd_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v[SEARCH_STEPS]),
        .in_ready  (r[SEARCH_STEPS]),
        .in_item   (itm[SEARCH_STEPS]),
        .out_valid (angles.valid),
        .out_ready (angles.ready),
        .pitch_deg (angles.pitch_deg),
        .yaw_deg   (angles.yaw_deg)
    );

endmodule

FILE: sv/vpyd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpyd_prep
// Three stages: magnitudes and signs, squares, sums of squares.
// ----------------------------------------------------------------------------
module vpyd_prep
    import vpyd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] vec_x,
    input  logic signed [CW-1:0] vec_y,
    input  logic signed [CW-1:0] vec_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_item
);

    logic          v1_reg, v2_reg, v3_reg;
    logic          r1, r2, r3;
    logic [CW-1:0] ax_reg, ay_reg, az_reg;
    logic [CW-1:0] ax_next, ay_next, az_next;
    logic          sx_reg, sy_reg, sz_reg;
    logic [SQ_W-1:0] x2_reg, y2_reg, z2_reg;
    logic          sx2_reg, sy2_reg, sz2_reg;
    item_t         item_reg, item_next;
    logic [D_W-1:0] h2, d;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        ax_next = vec_x[CW-1] ? (~vec_x + 1'b1) : vec_x;
        ay_next = vec_y[CW-1] ? (~vec_y + 1'b1) : vec_y;
        az_next = vec_z[CW-1] ? (~vec_z + 1'b1) : vec_z;
    end

    always_comb
    begin
        h2 = {2'b00, x2_reg} + {2'b00, y2_reg};
        d  = h2 + {2'b00, z2_reg};
        item_next.yaw.n       = {2'b00, y2_reg};
        item_next.yaw.d       = h2;
        item_next.yaw.k       = '0;
        item_next.yaw.whole   = (y2_reg == '0);
        item_next.yaw.full    = (x2_reg == '0);
        item_next.pitch.n     = {2'b00, z2_reg};
        item_next.pitch.d     = d;
        item_next.pitch.k     = '0;
        item_next.pitch.whole = (z2_reg == '0);
        item_next.pitch.full  = (h2 == '0);
        item_next.nx          = sx2_reg;
        item_next.ny          = sy2_reg;
        item_next.nz          = sz2_reg;
        item_next.hzero       = (h2 == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;
            sx_reg <= vec_x[CW-1];
            sy_reg <= vec_y[CW-1];
            sz_reg <= vec_z[CW-1];
        end
        if (r2)
        begin
            x2_reg  <= {{CW{1'b0}}, ax_reg} * {{CW{1'b0}}, ax_reg};
            y2_reg  <= {{CW{1'b0}}, ay_reg} * {{CW{1'b0}}, ay_reg};
            z2_reg  <= {{CW{1'b0}}, az_reg} * {{CW{1'b0}}, az_reg};
            sx2_reg <= sx_reg;
            sy2_reg <= sy_reg;
            sz2_reg <= sz_reg;
        end
        if (r3)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

FILE: sv/vpyd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpyd_step
// One binary search step for both angles: table products, then compare.
// ----------------------------------------------------------------------------
module vpyd_step
    import vpyd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [K_W-1:0] step_bit,
    input  logic           in_valid,
    output logic           in_ready,
    input  item_t          in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output item_t          out_item
);

    localparam int PP_W   = 32 + HALF_W;
    localparam int PROD_W = TAB_W + 2 * HALF_W;

    typedef struct packed {
        logic [K_W-1:0]  c;
        logic            ok;
        logic [PP_W-1:0] p00;
        logic [PP_W-1:0] p01;
        logic [PP_W-1:0] p10;
        logic [PP_W-1:0] p11;
    } trial_t;

    logic   va_reg, vb_reg;
    logic   ra, rb;
    item_t  itema_reg, itemb_reg, itemb_next;
    trial_t ty_reg, tp_reg, ty_next, tp_next;

    function automatic trial_t make_trial(angle_t a, logic [K_W-1:0] sb);
        trial_t              t;
        logic [TAB_W-1:0]    tv;
        logic [2*HALF_W-1:0] dd;
        t.c  = a.k | sb;
        t.ok = (t.c < K_W'(DEG_COUNT));
        tv   = SIN2_TAB[t.c];
        dd   = (2*HALF_W)'(a.d);
        t.p00 = {{HALF_W{1'b0}}, tv[31:0]}  * {32'd0, dd[HALF_W-1:0]};
        t.p01 = {{HALF_W{1'b0}}, tv[31:0]}  * {32'd0, dd[2*HALF_W-1:HALF_W]};
        t.p10 = {{HALF_W{1'b0}}, tv[63:32]} * {32'd0, dd[HALF_W-1:0]};
        t.p11 = {{HALF_W{1'b0}}, tv[63:32]} * {32'd0, dd[2*HALF_W-1:HALF_W]};
        return t;
    endfunction

    function automatic angle_t judge(angle_t a, trial_t t);
        angle_t            r;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] rhs;
        logic              pass;
        r    = a;
        prod = (PROD_W'(t.p11) << (32 + HALF_W)) + (PROD_W'(t.p10) << 32)
             + (PROD_W'(t.p01) << HALF_W) + PROD_W'(t.p00);
        rhs  = PROD_W'({a.n, 64'd0});
        pass = t.ok && (prod <= rhs);
        if (pass)
        begin
            r.k     = t.c;
            r.whole = a.whole || (prod == rhs);
        end
        return r;
    endfunction

    assign rb       = !vb_reg || out_ready;
    assign ra       = !va_reg || rb;
    assign in_ready = ra;

    always_comb
    begin
        ty_next          = make_trial(in_item.yaw, step_bit);
        tp_next          = make_trial(in_item.pitch, step_bit);
        itemb_next       = itema_reg;
        itemb_next.yaw   = judge(itema_reg.yaw, ty_reg);
        itemb_next.pitch = judge(itema_reg.pitch, tp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ra)
            begin
                va_reg <= in_valid;
            end
            if (rb)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ra)
        begin
            itema_reg <= in_item;
            ty_reg    <= ty_next;
            tp_reg    <= tp_next;
        end
        if (rb)
        begin
            itemb_reg <= itemb_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_item  = itemb_reg;

endmodule

FILE: sv/vpyd_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpyd_finish
// Quadrant and sign fold-up into degrees, output register.
// ----------------------------------------------------------------------------
module vpyd_finish
    import vpyd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DEG_W-1:0] pitch_deg,
    output logic [DEG_W-1:0] yaw_deg
);

    logic             v_reg;
    logic [DEG_W-1:0] pitch_reg, yaw_reg, pitch_next, yaw_next;
    logic [DEG_W-1:0] yfl, pfl, ymag;
    logic             ywhole;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        yfl    = in_item.yaw.full ? DEG_90 : DEG_W'(in_item.yaw.k);
        ywhole = in_item.yaw.full || in_item.yaw.whole;
        pfl    = in_item.pitch.full ? DEG_90 : DEG_W'(in_item.pitch.k);
        ymag   = in_item.nx ? (DEG_180 - (yfl + DEG_W'(!ywhole))) : yfl;
        if (in_item.hzero)
        begin
            yaw_next   = '0;
            pitch_next = (!in_item.nz && (in_item.pitch.n != '0)) ? DEG_90 : DEG_270;
        end
        else
        begin
            yaw_next   = (in_item.ny && (ymag != '0)) ? (DEG_360 - ymag) : ymag;
            pitch_next = (in_item.nz && (pfl != '0)) ? (DEG_360 - pfl) : pfl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign out_valid = v_reg;
    assign pitch_deg = pitch_reg;
    assign yaw_deg   = yaw_reg;

endmodule
